FILE: hw/rtl/ncx_pkg.sv
// Shared constants and types for the nonzero coordinate extractor.
package ncx_pkg;

  localparam int MAX_RANK       = 6;
  localparam int COORD_BITS     = 16;
  localparam int SIZE_BITS      = COORD_BITS + 1;
  localparam int RANK_BITS      = 3;
  localparam int AXIS_BITS      = 3;
  localparam int ELEM_BITS      = 64;
  localparam int TYPE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 17;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = 2;

  localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = {1'b1, {COORD_BITS{1'b0}}};

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ELEM_TYPE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TENSOR_RANK = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SIZE_0 = 3'd2;

  // element type codes
  localparam logic [TYPE_BITS-1:0] TYPE_F32  = 3'd0;
  localparam logic [TYPE_BITS-1:0] TYPE_I32  = 3'd1;
  localparam logic [TYPE_BITS-1:0] TYPE_I64  = 3'd2;
  localparam logic [TYPE_BITS-1:0] TYPE_I8   = 3'd3;
  localparam logic [TYPE_BITS-1:0] TYPE_BOOL = 3'd4;

  typedef struct packed {
    logic [TYPE_BITS-1:0]                elem_type;
    logic [RANK_BITS-1:0]                tensor_rank;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]  axis_size;
  } cfg_t;

  typedef struct packed {
    logic [RANK_BITS-1:0]                rank;
    logic [MAX_RANK-1:0][COORD_BITS-1:0] coords;
  } entry_t;

endpackage

FILE: hw/rtl/ncx_elem_if.sv
// Element input channel: valid/ready with element payload.
interface ncx_elem_if;
  import ncx_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] elem_bits;
  logic                 first_element;

  modport source (output valid, elem_bits, first_element, input ready);
  modport sink (input valid, elem_bits, first_element, output ready);
endinterface

FILE: hw/rtl/ncx_coord_if.sv
// Coordinate output channel: valid/ready with one axis coordinate per word.
interface ncx_coord_if;
  import ncx_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] axis_coord;
  logic [AXIS_BITS-1:0]  axis_number;
  logic                  last_axis;

  modport source (output valid, axis_coord, axis_number, last_axis, input ready);
  modport sink (input valid, axis_coord, axis_number, last_axis, output ready);
endinterface

FILE: hw/rtl/ncx_front.sv
// Front end: element truth test and mixed-radix coordinate counter.
module ncx_front (
  input  logic           clk,
  input  logic           rst,
  input  ncx_pkg::cfg_t  cfg,
  ncx_elem_if.sink       elems,
  input  logic           q_full,
  output logic           q_push,
  output ncx_pkg::entry_t q_data
);
  import ncx_pkg::*;

  logic [MAX_RANK-1:0][COORD_BITS-1:0] coord;
  logic [MAX_RANK-1:0][COORD_BITS-1:0] coord_next;
  logic [MAX_RANK-1:0][COORD_BITS-1:0] base;
  logic [MAX_RANK-1:0][SIZE_BITS-1:0]  eff_size;
  logic [RANK_BITS-1:0]                rank;
  logic                                is_true;
  logic                                accept;

  assign elems.ready = !q_full;
  assign accept      = elems.valid && elems.ready;

  always_comb begin
    if (cfg.tensor_rank == '0) begin
      rank = RANK_BITS'(1);
    end else if (cfg.tensor_rank > RANK_BITS'(MAX_RANK)) begin
      rank = RANK_BITS'(MAX_RANK);
    end else begin
      rank = cfg.tensor_rank;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      if (cfg.axis_size[i] == '0) begin
        eff_size[i] = SIZE_BITS'(1);
      end else if (cfg.axis_size[i] > SIZE_LIMIT) begin
        eff_size[i] = SIZE_LIMIT;
      end else begin
        eff_size[i] = cfg.axis_size[i];
      end
    end
  end

  // float32 ignores the sign bit; unknown codes test all 64 bits
  always_comb begin
    unique case (cfg.elem_type)
      TYPE_F32:          is_true = |elems.elem_bits[30:0];
      TYPE_I32:          is_true = |elems.elem_bits[31:0];
      TYPE_I64:          is_true = |elems.elem_bits;
      TYPE_I8, TYPE_BOOL: is_true = |elems.elem_bits[7:0];
      default:           is_true = |elems.elem_bits;
    endcase
  end

  assign base = elems.first_element ? '0 : coord;

  // innermost axis first; stop at the first axis that does not wrap
  always_comb begin
    logic                 carry;
    logic [SIZE_BITS-1:0] inc;
    coord_next = base;
    carry      = 1'b1;
    for (int i = MAX_RANK - 1; i >= 0; i--) begin
      inc = SIZE_BITS'(base[i]) + SIZE_BITS'(1);
      if (carry && (RANK_BITS'(i) < rank)) begin
        if (inc >= eff_size[i]) begin
          coord_next[i] = '0;
        end else begin
          coord_next[i] = inc[COORD_BITS-1:0];
          carry         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord <= '0;
    end else if (accept) begin
      coord <= coord_next;
    end
  end

  assign q_push        = accept && is_true;
  assign q_data.rank   = rank;
  assign q_data.coords = base;

endmodule

FILE: hw/rtl/ncx_fifo.sv
// Short queue of latched coordinates between front and back end.
module ncx_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ncx_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output ncx_pkg::entry_t pop_data,
  output logic            empty
);
  import ncx_pkg::*;

  entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic [QPTR_BITS:0]   count_next;

  assign full     = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (QPTR_BITS + 1)'(1);
    end else if (pop && !push) begin
      count_next = count - (QPTR_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/ncx_back.sv
// Back end: serializes a latched coordinate into one word per axis.
module ncx_back (
  input  logic            clk,
  input  logic            rst,
  input  ncx_pkg::entry_t q_data,
  input  logic            q_empty,
  output logic            q_pop,
  ncx_coord_if.source     coords
);
  import ncx_pkg::*;

  entry_t               cur;
  logic                 cur_valid;
  logic [AXIS_BITS-1:0] idx;
  logic                 out_free;
  logic                 emit;
  logic                 at_last;

  assign out_free = !coords.valid || coords.ready;
  assign emit     = cur_valid && out_free;
  assign at_last  = (idx == AXIS_BITS'(cur.rank - RANK_BITS'(1)));
  assign q_pop    = !q_empty && (!cur_valid || (emit && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (emit && at_last) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      idx <= idx + AXIS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coords.valid <= 1'b0;
    end else if (emit) begin
      coords.valid <= 1'b1;
    end else if (coords.ready) begin
      coords.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coords.axis_coord  <= cur.coords[idx];
      coords.axis_number <= idx;
      coords.last_axis   <= at_last;
    end
  end

endmodule

FILE: hw/rtl/nonzero_coordinate_extractor.sv
// Streaming argwhere: emits the coordinate of every nonzero element, one axis per word.
// Elements are taken one per cycle whenever the 4-entry coordinate queue has room; the
// front end tests each element and steps a row-major coordinate counter in that cycle.
// A true element costs one output word per axis of its rank (tensor_rank held to 1..6),
// sent one per cycle by the back-end serializer while the output is ready, so sustained
// throughput is one element per cycle on sparse data; the output port caps dense runs.
// Words pass the queue slot, the back-end entry and output registers. first_element
// restarts the counter at zero; past the last element the outermost axis wraps.
// The user writes configuration via cfg_we/cfg_index/cfg_data only while idle (unchecked).
module nonzero_coordinate_extractor (
  input  logic                                 clk,
  input  logic                                 rst,
  ncx_elem_if.sink                             elems,
  ncx_coord_if.source                          coords,
  input  logic                                 cfg_we,
  input  logic [ncx_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ncx_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import ncx_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  entry_t q_push_data;
  logic   q_full;
  logic   q_pop;
  entry_t q_pop_data;
  logic   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.elem_type   <= TYPE_F32;
      cfg.tensor_rank <= RANK_BITS'(1);
      for (int i = 0; i < MAX_RANK; i++) begin
        cfg.axis_size[i] <= SIZE_BITS'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEM_TYPE:   cfg.elem_type   <= cfg_data[TYPE_BITS-1:0];
        REG_TENSOR_RANK: cfg.tensor_rank <= cfg_data[RANK_BITS-1:0];
        default: cfg.axis_size[AXIS_BITS'(cfg_index - REG_AXIS_SIZE_0)] <=
                   cfg_data[SIZE_BITS-1:0];
      endcase
    end
  end

  ncx_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .elems  (elems),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  ncx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  ncx_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_pop_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .coords  (coords)
  );

endmodule

FILE: hw/rtl/ncx_checker.sv
// Port-level checks for the nonzero coordinate extractor and their bind.
module ncx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           coords_valid,
  input logic                           coords_ready,
  input logic [ncx_pkg::COORD_BITS-1:0] axis_coord,
  input logic [ncx_pkg::AXIS_BITS-1:0]  axis_number,
  input logic                           last_axis
);
  import ncx_pkg::*;

  logic word_taken;
  assign word_taken = coords_valid && coords_ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    coords_valid && !coords_ready |=> coords_valid && $stable(axis_coord) &&
      $stable(axis_number) && $stable(last_axis))
    else $error("output word changed while stalled");

  a_axis_step: assert property (@(posedge clk) disable iff (rst)
    word_taken && !last_axis |=> coords_valid &&
      (axis_number == $past(axis_number) + AXIS_BITS'(1)))
    else $error("axis words not back to back in order");

  a_axis_restart: assert property (@(posedge clk) disable iff (rst)
    word_taken && last_axis |=> !coords_valid || (axis_number == '0))
    else $error("new coordinate does not start at the outermost axis");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    coords_valid |-> (axis_number < AXIS_BITS'(MAX_RANK)) &&
      (last_axis || (axis_number < AXIS_BITS'(MAX_RANK - 1))))
    else $error("axis number beyond rank limit");

endmodule

bind nonzero_coordinate_extractor ncx_checker u_ncx_checker (
  .clk          (clk),
  .rst          (rst),
  .coords_valid (coords.valid),
  .coords_ready (coords.ready),
  .axis_coord   (coords.axis_coord),
  .axis_number  (coords.axis_number),
  .last_axis    (coords.last_axis)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nonzero coordinate extractor, random and directed tensors.
module tb_top;
  import ncx_pkg::*;

  typedef struct packed {
    logic [ELEM_BITS-1:0] bits;
    logic                 first;
  } elem_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] coord;
    logic [AXIS_BITS-1:0]  axis;
    logic                  last;
  } coord_word_t;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 180;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  ncx_elem_if  elems_if ();
  ncx_coord_if coords_if ();

  nonzero_coordinate_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .elems     (elems_if),
    .coords    (coords_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [TYPE_BITS-1:0]  cur_type;
  logic [RANK_BITS-1:0]  cur_rank;
  logic [SIZE_BITS-1:0]  cur_size [MAX_RANK];
  logic [COORD_BITS-1:0] position [MAX_RANK];

  elem_word_t  elem_backlog [$];
  coord_word_t coord_expect [$];
  int          shape [MAX_RANK];
  int          queued_total = 0;
  int          taken_total = 0;
  int          error_count = 0;
  int          hold_left = 0;
  bit          elem_fire = 1'b0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  function automatic int axis_limit(int a);
    if (cur_size[a] == '0) return 1;
    if (cur_size[a] > SIZE_LIMIT) return int'(SIZE_LIMIT);
    return int'(cur_size[a]);
  endfunction

  function automatic int used_rank();
    if (cur_rank == '0) return 1;
    if (cur_rank > MAX_RANK) return MAX_RANK;
    return int'(cur_rank);
  endfunction

  function automatic bit is_true(logic [ELEM_BITS-1:0] bits);
    case (cur_type)
      TYPE_F32: return |bits[30:0];
      TYPE_I32: return |bits[31:0];
      TYPE_I8, TYPE_BOOL: return |bits[7:0];
      default: return |bits;
    endcase
  endfunction

  function automatic void step_coordinates(elem_word_t w);
    int          rank;
    bit          carry;
    coord_word_t cw;
    rank = used_rank();
    if (w.first) begin
      for (int a = 0; a < MAX_RANK; a++) position[a] = '0;
    end
    if (is_true(w.bits)) begin
      for (int a = 0; a < rank; a++) begin
        cw.coord = position[a];
        cw.axis  = AXIS_BITS'(a);
        cw.last  = (a == rank - 1);
        coord_expect.push_back(cw);
      end
    end
    carry = 1'b1;
    for (int a = rank - 1; a >= 0 && carry; a--) begin
      if (int'(position[a]) + 1 >= axis_limit(a)) begin
        position[a] = '0;
      end else begin
        position[a] = position[a] + 1'b1;
        carry = 1'b0;
      end
    end
  endfunction

  task automatic flag_mismatch(string msg);
    if (error_count < 100) $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // output checker and input tracker
  always @(posedge clk) begin
    coord_word_t want;
    if (rst) begin
      elem_fire <= 1'b0;
    end else begin
      if (coords_if.valid && coords_if.ready) begin
        if (coord_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected word coord %0d axis %0d last %0d",
                                  coords_if.axis_coord, coords_if.axis_number,
                                  coords_if.last_axis));
        end else begin
          want = coord_expect.pop_front();
          if (coords_if.axis_coord !== want.coord)
            flag_mismatch($sformatf("axis_coord %0d, want %0d", coords_if.axis_coord,
                                    want.coord));
          if (coords_if.axis_number !== want.axis)
            flag_mismatch($sformatf("axis_number %0d, want %0d", coords_if.axis_number,
                                    want.axis));
          if (coords_if.last_axis !== want.last)
            flag_mismatch($sformatf("last_axis %0d, want %0d", coords_if.last_axis,
                                    want.last));
        end
      end
      elem_fire <= elems_if.valid && elems_if.ready;
      if (elems_if.valid && elems_if.ready) begin
        step_coordinates({elems_if.elem_bits, elems_if.first_element});
        taken_total++;
      end
    end
  end

  // element driver
  always @(negedge clk) begin
    elem_word_t w;
    if (rst) begin
      elems_if.valid <= 1'b0;
    end else if (!elems_if.valid || elem_fire) begin
      if (elem_backlog.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
        w = elem_backlog.pop_front();
        elems_if.valid         <= 1'b1;
        elems_if.elem_bits     <= w.bits;
        elems_if.first_element <= w.first;
      end else begin
        elems_if.valid <= 1'b0;
      end
    end
  end

  // coordinate sink, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      coords_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      coords_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      coords_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      coords_if.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic offer(logic [ELEM_BITS-1:0] bits, logic first);
    elem_word_t w;
    w.bits  = bits;
    w.first = first;
    elem_backlog.push_back(w);
    queued_total++;
  endtask

  task automatic drain();
    while (taken_total != queued_total || coord_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_ELEM_TYPE) cur_type = val[TYPE_BITS-1:0];
    else if (idx == REG_TENSOR_RANK) cur_rank = val[RANK_BITS-1:0];
    else cur_size[idx - REG_AXIS_SIZE_0] = val;
  endtask

  task automatic program_regs(int etype, int rank);
    write_reg(REG_ELEM_TYPE, CFG_DATA_BITS'(etype));
    write_reg(REG_TENSOR_RANK, CFG_DATA_BITS'(rank));
    for (int a = 0; a < MAX_RANK; a++)
      write_reg(CFG_INDEX_BITS'(REG_AXIS_SIZE_0 + a), CFG_DATA_BITS'(shape[a]));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ELEM_BITS-1:0] make_elem(int zero_pct);
    logic [ELEM_BITS-1:0] v;
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(6))
      0: v = {$urandom, $urandom};
      1: v = 64'd1 << $urandom_range(63);
      2: v = {$urandom, 32'h8000_0000};
      3: v = {$urandom, 32'h0};
      4: v = {$urandom, $urandom} & ~64'hFF;
      default: v = 64'($urandom_range(1, 255));
    endcase
    return v;
  endfunction

  task automatic random_phase();
    int etype;
    int rank;
    int k;
    int span;
    int count;
    int zero_pct;
    etype = ($urandom_range(19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    if ($urandom_range(19) == 0) rank = $urandom_range(1) ? 0 : 7;
    else rank = $urandom_range(1, MAX_RANK);
    for (int a = 0; a < MAX_RANK; a++) begin
      k = $urandom_range(24);
      case (k)
        0: shape[a] = 0;
        1: shape[a] = $urandom_range(65537, 131071);
        2: shape[a] = $urandom_range(1, 65536);
        3: shape[a] = 65536;
        default: shape[a] = $urandom_range(1, 4);
      endcase
    end
    program_regs(etype, rank);
    span = 1;
    for (int a = 0; a < used_rank(); a++) begin
      span = span * axis_limit(a);
      if (span > 64) span = 64;
    end
    zero_pct = $urandom_range(0, 90);
    repeat ($urandom_range(1, 3)) begin
      count = (span <= 40) ? span : $urandom_range(4, 24);
      if ($urandom_range(4) == 0) count += $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
        offer(make_elem(zero_pct),
              (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
      end
    end
    drain();
  endtask

  initial begin
    elems_if.valid         = 1'b0;
    elems_if.elem_bits     = '0;
    elems_if.first_element = 1'b0;
    coords_if.ready        = 1'b0;
    cur_type = TYPE_F32;
    cur_rank = 3'd1;
    for (int a = 0; a < MAX_RANK; a++) begin
      cur_size[a] = 17'd1;
      position[a] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // float32: signed zeros are false, denormals and NaN are true
    shape = '{2, 3, 4, 1, 1, 1};
    program_regs(TYPE_F32, 3);
    offer(64'h3F80_0000, 1'b1);
    offer(64'h8000_0000, 1'b0);
    offer(64'h0, 1'b0);
    offer(64'h0000_0001, 1'b0);
    offer(64'h7FC0_0000, 1'b0);
    offer(64'hFFFF_FFFF_0000_0000, 1'b0);
    offer(64'hBF80_0000, 1'b1);
    drain();

    // int32 with overrun past the last element
    shape = '{2, 2, 1, 1, 1, 1};
    program_regs(TYPE_I32, 2);
    offer(64'h1_0000_0000, 1'b1);
    offer(64'h8000_0000, 1'b0);
    offer(64'hFFFF_FFFF, 1'b0);
    offer(64'h1, 1'b0);
    offer(64'h1, 1'b0);
    drain();

    // int8, no restart: the counters carry on from where the last test left them
    shape = '{1, 2, 1, 2, 1, 2};
    program_regs(TYPE_I8, 6);
    offer(64'h100, 1'b0);
    offer(64'hFF, 1'b0);
    offer(64'h80, 1'b0);
    drain();

    shape = '{65536, 1, 1, 1, 1, 1};
    program_regs(TYPE_BOOL, 1);
    offer(64'hFFFF_FFFF_FFFF_FF00, 1'b1);
    offer(64'h1, 1'b0);
    drain();

    shape = '{3, 3, 3, 3, 1, 1};
    program_regs(TYPE_I64, 4);
    offer(64'h8000_0000_0000_0000, 1'b1);
    offer(64'h0, 1'b0);
    drain();

    // undefined type, zero rank, zero and oversized sizes
    shape = '{0, 131071, 0, 131071, 0, 65536};
    program_regs(7, 0);
    offer(64'h1_0000_0000, 1'b0);
    offer(64'h0010_0000_0000_0000, 1'b0);
    drain();

    shape = '{131071, 2, 3, 1, 1, 2};
    program_regs(TYPE_F32, 7);
    offer(64'h4000_0000, 1'b0);
    offer(64'h8000_0000_0000_0000, 1'b0);
    offer(64'h0000_0000_0080_0000, 1'b0);
    drain();

    // dense run against a stalled sink: the input must back up
    shape = '{2, 2, 2, 2, 2, 2};
    program_regs(TYPE_I8, 6);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      offer(64'($urandom_range(1, 255)), i == 0);
    end
    drain();

    for (int p = 0; queued_total < RANDOM_ITEMS; p++) begin
      steady = (p == 1);
      random_phase();
    end
    steady = 1'b0;

    drain();
    if (coord_expect.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", coord_expect.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
